@@ design/dasv_pkg.sv @@
// Shared types, constants and character-class helpers for the address string validator.
package dasv_pkg;

  localparam int unsigned HEX_DIGITS  = 40;
  localparam int unsigned MAX_NESTING = 127;

  localparam int unsigned HEX_CNT_W = $clog2(HEX_DIGITS + 1);
  localparam int unsigned DEPTH_W   = $clog2(MAX_NESTING + 1);

  localparam logic [HEX_CNT_W-1:0] HEX_FULL  = HEX_CNT_W'(HEX_DIGITS);
  localparam logic [DEPTH_W-1:0]   DEPTH_MAX = DEPTH_W'(MAX_NESTING);

  localparam logic [1:0] PREFIX_LEN = 2'd3;

  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_COLON  = 8'h3a;
  localparam logic [7:0] CH_LPAREN = 8'h28;
  localparam logic [7:0] CH_RPAREN = 8'h29;
  localparam logic [7:0] CH_R      = 8'h52;
  localparam logic [7:0] CH_E      = 8'h45;

  typedef struct packed {
    logic [1:0]           prefix_pos;
    logic                 in_token;
    logic                 seen_colon;
    logic                 type_len_nonzero;
    logic [HEX_CNT_W-1:0] hex_count;
    logic [DEPTH_W-1:0]   depth;
    logic                 paren_pending;
    logic                 prev_space;
    logic                 failed;
  } dasv_state_t;

  function automatic logic [7:0] lead_char(input logic [1:0] pos);
    logic [7:0] c;
    unique case (pos)
      2'd0:    c = CH_R;
      2'd1:    c = CH_E;
      default: c = CH_SPACE;
    endcase
    return c;
  endfunction

  function automatic logic is_digit(input logic [7:0] c);
    return (c >= 8'h30) && (c <= 8'h39);
  endfunction

  function automatic logic is_alnum(input logic [7:0] c);
    return is_digit(c) || ((c >= 8'h61) && (c <= 8'h7a)) || ((c >= 8'h41) && (c <= 8'h5a));
  endfunction

  function automatic logic is_hex(input logic [7:0] c);
    return is_digit(c) || ((c >= 8'h61) && (c <= 8'h66)) || ((c >= 8'h41) && (c <= 8'h46));
  endfunction

  function automatic logic token_complete(input dasv_state_t s);
    return s.seen_colon && s.type_len_nonzero && (s.hex_count == HEX_FULL);
  endfunction

endpackage

@@ design/dasv_if.sv @@
// Valid/ready channel interfaces for the character input and the verdict output.
interface dasv_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] ch;
  logic       last;

  modport source (output valid, output ch, output last, input ready);
  modport sink (input valid, input ch, input last, output ready);
endinterface

interface dasv_out_if;
  logic valid;
  logic ready;
  logic valid_res;

  modport source (output valid, output valid_res, input ready);
  modport sink (input valid, input valid_res, output ready);
endinterface

@@ design/dag_address_string_validator.sv @@
// Address string validator: one character per transfer in, one verdict per string out.
// Each character is captured in an input register and processed against the running
// string state while it sits there; the verdict for a string is loaded into the output
// register when its last character is processed. One character is taken every cycle,
// unless a last character waits on a stalled output; the verdict is registered.
// A stalled output only holds the input register while it carries a last character.
module dag_address_string_validator (
  input  logic              clk_i,
  input  logic              rst_ni,
  dasv_in_if.sink           in_i,
  dasv_out_if.source        out_o
);
  import dasv_pkg::*;

  logic        s1_valid_q;
  logic [7:0]  s1_ch_q;
  logic        s1_last_q;
  logic        out_valid_q;
  logic        out_res_q;
  dasv_state_t state_q;
  dasv_state_t state_d;
  logic        res_d;
  logic        out_free;
  logic        s1_go;
  logic        in_fire;

  dasv_step u_step (
    .st_i        (state_q),
    .ch_i        (s1_ch_q),
    .st_o        (state_d),
    .valid_res_o (res_d)
  );

  assign out_free   = !out_valid_q || out_o.ready;
  assign s1_go      = s1_valid_q && (!s1_last_q || out_free);
  assign in_i.ready = !s1_valid_q || s1_go;
  assign in_fire    = in_i.valid && in_i.ready;

  assign out_o.valid     = out_valid_q;
  assign out_o.valid_res = out_res_q;

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      s1_ch_q   <= in_i.ch;
      s1_last_q <= in_i.last;
    end
    if (s1_go && s1_last_q) begin
      out_res_q <= res_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      state_q     <= '0;
    end else begin
      if (in_fire) begin
        s1_valid_q <= 1'b1;
      end else if (s1_go) begin
        s1_valid_q <= 1'b0;
      end
      if (s1_go) begin
        state_q <= s1_last_q ? '0 : state_d;
      end
      if (s1_go && s1_last_q) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

`ifndef SYNTH
  // a new verdict only follows a processed last character
  a_out_from_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(s1_valid_q && s1_last_q))
    else $error("verdict without a last character");

  a_depth_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q.depth <= DEPTH_MAX)
    else $error("nesting depth out of range");

  a_hex_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q.hex_count <= HEX_FULL)
    else $error("hex count out of range");

  // body state stays clear until the prefix is matched
  a_prefix_first: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q.prefix_pos < PREFIX_LEN) |-> (!state_q.in_token && (state_q.depth == '0)))
    else $error("body state before prefix complete");
`endif

endmodule

@@ design/dasv_step.sv @@
// Per-character next-state logic and end-of-string verdict.
module dasv_step (
  input  dasv_pkg::dasv_state_t st_i,
  input  logic [7:0]            ch_i,
  output dasv_pkg::dasv_state_t st_o,
  output logic                  valid_res_o
);
  import dasv_pkg::*;

  dasv_state_t nx;
  logic        colon;
  logic        tln;
  logic [HEX_CNT_W-1:0] hexc;
  logic        is_paren;

  always_comb begin
    nx       = st_i;
    colon    = st_i.seen_colon;
    tln      = st_i.type_len_nonzero;
    hexc     = st_i.hex_count;
    is_paren = (ch_i == CH_LPAREN) || (ch_i == CH_RPAREN);
    if (!st_i.failed) begin
      if (st_i.prefix_pos < PREFIX_LEN) begin
        if (ch_i != lead_char(st_i.prefix_pos)) begin
          nx.failed = 1'b1;
        end else begin
          nx.prefix_pos = st_i.prefix_pos + 2'd1;
        end
        nx.prev_space = (ch_i == CH_SPACE);
      end else begin
        if (st_i.paren_pending && (ch_i != CH_SPACE)) begin
          nx.failed = 1'b1;
        end
        nx.paren_pending = 1'b0;
        if (ch_i == CH_SPACE) begin
          if (st_i.in_token) begin
            if (!token_complete(st_i)) begin
              nx.failed = 1'b1;
            end
            nx.in_token = 1'b0;
          end
          nx.prev_space = 1'b1;
        end else if (is_paren) begin
          if (!st_i.prev_space) begin
            nx.failed = 1'b1;
          end
          if (ch_i == CH_LPAREN) begin
            if (st_i.depth >= DEPTH_MAX) begin
              nx.failed = 1'b1;
            end else begin
              nx.depth = st_i.depth + DEPTH_W'(1);
            end
          end else begin
            if (st_i.depth == '0) begin
              nx.failed = 1'b1;
            end else begin
              nx.depth = st_i.depth - DEPTH_W'(1);
            end
          end
          nx.paren_pending = 1'b1;
          nx.prev_space    = 1'b0;
        end else begin
          if (!st_i.in_token) begin
            nx.in_token = 1'b1;
            colon       = 1'b0;
            tln         = 1'b0;
            hexc        = '0;
          end
          nx.seen_colon       = colon;
          nx.type_len_nonzero = tln;
          nx.hex_count        = hexc;
          if (ch_i == CH_COLON) begin
            if (colon || !tln) begin
              nx.failed = 1'b1;
            end else begin
              nx.seen_colon = 1'b1;
            end
          end else if (colon) begin
            if (!is_hex(ch_i) || (hexc >= HEX_FULL)) begin
              nx.failed = 1'b1;
            end else begin
              nx.hex_count = hexc + HEX_CNT_W'(1);
            end
          end else if (!is_alnum(ch_i)) begin
            nx.failed = 1'b1;
          end else begin
            nx.type_len_nonzero = 1'b1;
          end
          nx.prev_space = 1'b0;
        end
      end
    end
  end

  assign st_o        = nx;
  assign valid_res_o = !(nx.failed || (nx.prefix_pos < PREFIX_LEN) ||
                         (nx.in_token && !token_complete(nx)) || (nx.depth != '0));

endmodule

@@ sim/dag_address_string_validator_tb.sv @@
// Self-checking testbench for the address string validator: directed and random strings.
`timescale 1ns / 100ps

module dag_address_string_validator_tb;
  import dasv_pkg::*;

  typedef enum logic [2:0] {
    KIND_SPACE, KIND_LPAREN, KIND_RPAREN, KIND_COLON, KIND_HEX, KIND_ALPHA, KIND_OTHER
  } char_kind_e;

  localparam logic [7:0] LEAD_TEXT [3] = '{CH_R, CH_E, CH_SPACE};
  localparam string HEX_SET   = "0123456789abcdefABCDEF";
  localparam string ALNUM_SET = "0123456789abcdefghijklmnopqrstuvwxyzABCDEFGHIJKLMNOPQRSTUVWXYZ";
  localparam int unsigned HOLD_OFF_CYCLES = 150;

  logic clk_i;
  logic rst_ni;

  dasv_in_if  in_if ();
  dasv_out_if out_if ();

  dag_address_string_validator u_top (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if),
    .out_o  (out_if)
  );

  // running string state of the predictor
  logic [1:0]           lead_cnt;
  logic                 tok_open;
  logic                 tok_colon;
  logic                 tok_has_type;
  logic [HEX_CNT_W-1:0] tok_hex;
  logic [DEPTH_W-1:0]   nest;
  logic                 after_paren;
  logic                 after_space;
  logic                 broken;

  logic verdict_q [$];
  int   errors;
  int   chars_sent;
  int   strings_sent;
  bit   src_idle;
  bit   snk_idle;
  bit   hold_off_req;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #5ms;
    $display("status: fail");
    $finish;
  end

  function automatic char_kind_e char_kind(input logic [7:0] c);
    if (c == CH_SPACE)  return KIND_SPACE;
    if (c == CH_LPAREN) return KIND_LPAREN;
    if (c == CH_RPAREN) return KIND_RPAREN;
    if (c == CH_COLON)  return KIND_COLON;
    if ((c >= "0" && c <= "9") || (c >= "a" && c <= "f") || (c >= "A" && c <= "F"))
      return KIND_HEX;
    if ((c >= "g" && c <= "z") || (c >= "G" && c <= "Z")) return KIND_ALPHA;
    return KIND_OTHER;
  endfunction

  task automatic clear_string_state();
    lead_cnt     = '0;
    tok_open     = 1'b0;
    tok_colon    = 1'b0;
    tok_has_type = 1'b0;
    tok_hex      = '0;
    nest         = '0;
    after_paren  = 1'b0;
    after_space  = 1'b0;
    broken       = 1'b0;
  endtask

  function automatic logic token_done();
    return tok_colon && tok_has_type && (tok_hex == HEX_FULL);
  endfunction

  // advance the predicted string state by one transferred character
  task automatic predict_verdict(input logic [7:0] c, input logic is_last);
    char_kind_e k;
    k = char_kind(c);
    if (!broken) begin
      if (lead_cnt < PREFIX_LEN) begin
        if (c != LEAD_TEXT[lead_cnt]) broken = 1'b1;
        else lead_cnt = lead_cnt + 2'd1;
        after_space = (k == KIND_SPACE);
      end else begin
        if (after_paren && k != KIND_SPACE) broken = 1'b1;
        after_paren = 1'b0;
        case (k)
          KIND_SPACE: begin
            if (tok_open && !token_done()) broken = 1'b1;
            tok_open    = 1'b0;
            after_space = 1'b1;
          end
          KIND_LPAREN, KIND_RPAREN: begin
            if (!after_space) broken = 1'b1;
            if (k == KIND_LPAREN) begin
              if (nest >= DEPTH_MAX) broken = 1'b1;
              else nest = nest + DEPTH_W'(1);
            end else begin
              if (nest == '0) broken = 1'b1;
              else nest = nest - DEPTH_W'(1);
            end
            after_paren = 1'b1;
            after_space = 1'b0;
          end
          default: begin
            if (!tok_open) begin
              tok_open     = 1'b1;
              tok_colon    = 1'b0;
              tok_has_type = 1'b0;
              tok_hex      = '0;
            end
            if (k == KIND_COLON) begin
              if (tok_colon || !tok_has_type) broken = 1'b1;
              else tok_colon = 1'b1;
            end else if (tok_colon) begin
              if (k != KIND_HEX || tok_hex >= HEX_FULL) broken = 1'b1;
              else tok_hex = tok_hex + HEX_CNT_W'(1);
            end else if (k == KIND_OTHER) begin
              broken = 1'b1;
            end else begin
              tok_has_type = 1'b1;
            end
            after_space = 1'b0;
          end
        endcase
      end
    end
    if (is_last) begin
      if (!broken) begin
        if (lead_cnt < PREFIX_LEN) broken = 1'b1;
        else if (tok_open && !token_done()) broken = 1'b1;
        else if (nest != '0) broken = 1'b1;
      end
      verdict_q.push_back(!broken);
      clear_string_state();
    end
  endtask

  // called and returns at a falling edge
  task automatic send_char(input logic [7:0] c, input logic is_last);
    int gap;
    gap = src_idle ? $urandom_range(0, 19) : 0;
    if (gap > 0) begin
      in_if.valid = 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_if.valid = 1'b1;
    in_if.ch    = c;
    in_if.last  = is_last;
    @(posedge clk_i);
    while (!in_if.ready) @(posedge clk_i);
    predict_verdict(c, is_last);
    chars_sent++;
    @(negedge clk_i);
  endtask

  task automatic send_string(input string s);
    for (int i = 0; i < s.len(); i++) send_char(s[i], i == s.len() - 1);
    strings_sent++;
  endtask

  task automatic wait_drain();
    in_if.valid = 1'b0;
    for (int i = 0; i < 4000 && verdict_q.size() != 0; i++) @(negedge clk_i);
    repeat (4) @(negedge clk_i);
  endtask

  function automatic string pick_chars(input string set, input int n);
    string s;
    s = "";
    for (int i = 0; i < n; i++) s = {s, set.substr(0, 0)};
    for (int i = 0; i < n; i++) s[i] = set[$urandom_range(0, set.len() - 1)];
    return s;
  endfunction

  function automatic string make_token(input int hex_len);
    return {pick_chars(ALNUM_SET, $urandom_range(1, 4)), ":", pick_chars(HEX_SET, hex_len)};
  endfunction

  function automatic string good_token();
    return make_token(HEX_DIGITS);
  endfunction

  // mostly well-formed address: tokens (some with a wrong hex length) and balanced parens, random spacing
  function automatic string make_address();
    string s;
    int    elems;
    int    lvl;
    int    pick;
    s     = "RE ";
    elems = $urandom_range(0, 4);
    lvl   = 0;
    for (int i = 0; i < elems; i++) begin
      pick = $urandom_range(0, 3);
      if (pick == 0 && lvl < 3) begin
        s = {s, "("};
        lvl++;
      end else if (pick == 1 && lvl > 0) begin
        s = {s, ")"};
        lvl--;
      end else begin
        s = {s, make_token($urandom_range(0, 9) == 0 ? HEX_DIGITS - 1 + $urandom_range(0, 2)
                                                     : HEX_DIGITS)};
      end
      s = {s, ($urandom_range(0, 4) == 0) ? "  " : " "};
    end
    while (lvl > 0) begin
      s = {s, ") "};
      lvl--;
    end
    if (s.len() > 3 && $urandom_range(0, 1) == 0) s = s.substr(0, s.len() - 2);
    return s;
  endfunction

  function automatic string mutate(input string s);
    string one;
    int    pos;
    one = " ";
    one[0] = $urandom_range(1, 255);
    pos = $urandom_range(0, s.len() - 1);
    case ($urandom_range(0, 2))
      0: s[pos] = one[0];
      1: if (s.len() > 1) s = s.substr(0, $urandom_range(0, s.len() - 2));
      default: s = {s.substr(0, pos - 1), one, s.substr(pos, s.len() - 1)};
    endcase
    return s;
  endfunction

  function automatic string noise_string();
    string s;
    s = pick_chars(" ", $urandom_range(1, 20));
    for (int i = 0; i < s.len(); i++) s[i] = $urandom_range(1, 255);
    if ($urandom_range(0, 1) == 0) s = {"RE ", s};
    return s;
  endfunction

  task automatic test_prefix();
    send_string("R");
    send_string("RE");
    send_string("RE ");
    send_string("RE  ");
    send_string("RX ");
    send_string({"rE ", good_token()});
  endtask

  task automatic test_tokens();
    send_string({"RE ", good_token()});
    send_string({"RE ", good_token(), " ", good_token(), " "});
    send_string({"RE ", make_token(HEX_DIGITS - 1)});
    send_string({"RE ", make_token(HEX_DIGITS + 1)});
    send_string({"RE ", make_token(HEX_DIGITS), "g"});
    send_string({"RE :", pick_chars(HEX_SET, HEX_DIGITS)});
    send_string({"RE ab::", pick_chars(HEX_SET, HEX_DIGITS)});
    send_string({"RE a_b:", pick_chars(HEX_SET, HEX_DIGITS)});
    send_string({"RE zZ9:", pick_chars(HEX_SET, 5), "G", pick_chars(HEX_SET, 34)});
    send_string("RE x");
  endtask

  task automatic test_parens();
    send_string({"RE ( ", good_token(), " )"});
    send_string("RE ( )");
    send_string("RE ( ) ");
    send_string({"RE (", good_token(), " )"});
    send_string("RE ( )( )");
    send_string("RE )");
    send_string("RE (");
    send_string("RE ( ( )");
  endtask

  task automatic test_nesting_limits();
    string opens;
    string closes;
    opens  = "";
    closes = "";
    for (int i = 0; i < MAX_NESTING; i++) begin
      opens  = {opens, "( "};
      closes = {closes, (i == 0) ? ")" : " )"};
    end
    send_string({"RE ", opens, closes});
    send_string({"RE ", opens, "( ", closes, " )"});
  endtask

  task automatic test_odd_chars();
    string s;
    s = "RE x";
    s[3] = 8'd1;
    send_string(s);
    s[3] = 8'd255;
    send_string(s);
    s[3] = 8'd128;
    send_string(s);
    s = "RE  ";
    s[3] = 8'd255;
    send_string({"RE ", good_token(), s.substr(3, 3), " ", good_token()});
  endtask

  // long receiver stall while the sender streams short strings
  task automatic test_backpressure();
    src_idle     = 1'b0;
    hold_off_req = 1'b1;
    for (int i = 0; i < 40; i++) send_string((i % 3 == 0) ? "RE" : "RE ");
    wait_drain();
  endtask

  task automatic test_random_strings();
    int  pick;
    int  n;
    n = 0;
    while (chars_sent < 2000 || n < 10) begin
      if (n % 15 == 0) begin
        src_idle = $urandom_range(0, 2) != 0;
        snk_idle = $urandom_range(0, 2) != 0;
      end
      pick = $urandom_range(0, 9);
      if (pick < 7) send_string(make_address());
      else if (pick < 9) send_string(mutate(make_address()));
      else send_string(noise_string());
      n++;
    end
  endtask

  // result side: random stall before each transfer, plus one long hold-off on request
  initial begin
    int gap;
    out_if.ready = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_off_req) begin
        gap = HOLD_OFF_CYCLES;
        hold_off_req = 1'b0;
      end else begin
        gap = snk_idle ? $urandom_range(0, 19) : 0;
      end
      if (gap > 0) begin
        out_if.ready = 1'b0;
        repeat (gap) @(negedge clk_i);
      end
      out_if.ready = 1'b1;
      @(posedge clk_i);
      while (!out_if.valid) @(posedge clk_i);
    end
  end

  always @(posedge clk_i) begin
    logic want;
    if (rst_ni && out_if.valid && out_if.ready) begin
      if (verdict_q.size() == 0) begin
        $display("%0t: unexpected verdict, expected none, got %0b", $time, out_if.valid_res);
        errors++;
      end else begin
        want = verdict_q.pop_front();
        if (out_if.valid_res !== want) begin
          $display("%0t: verdict mismatch, expected %0b, got %0b", $time, want,
                   out_if.valid_res);
          errors++;
        end
      end
    end
  end

  initial begin
    errors       = 0;
    chars_sent   = 0;
    strings_sent = 0;
    src_idle     = 1'b1;
    snk_idle     = 1'b1;
    hold_off_req = 1'b0;
    clear_string_state();
    in_if.valid = 1'b0;
    in_if.ch    = CH_SPACE;
    in_if.last  = 1'b0;
    rst_ni      = 1'b0;
    repeat (7) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    test_prefix();
    test_tokens();
    test_parens();
    test_nesting_limits();
    test_odd_chars();
    test_backpressure();
    test_random_strings();
    wait_drain();
    repeat (10) @(negedge clk_i);

    if (verdict_q.size() != 0) begin
      $display("%0t: verdicts missing, expected %0d more, got none", $time, verdict_q.size());
      errors++;
    end
    if (errors == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

@@ dag_address_string_validator.f @@
design/dasv_pkg.sv
design/dasv_if.sv
design/dasv_step.sv
design/dag_address_string_validator.sv
sim/dag_address_string_validator_tb.sv
